[sv/lome_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lome_pkg: shared types and constants of the limit order matching engine
// Holds default sizes, command, side and status codes, and the request and
// result records that move between the engine's parts.
// ----------------------------------------------------------------------------
package lome_pkg;

    // default sizes
    localparam int LOME_PRICE_LEVELS = 1024;
    localparam int LOME_ORDER_SLOTS  = 1024;
    localparam int LOME_MAX_FILLS    = 63;

    // command codes
    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;

    // side codes
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    // final status codes
    localparam logic [2:0] ST_RESTED    = 3'd0;
    localparam logic [2:0] ST_NOLEFT    = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOTFOUND  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_FILLDROP  = 3'd5;

    // classified request, as queued between front and back
    typedef struct packed {
        logic        cmd;
        logic        side;
        logic [9:0]  price;     // already clamped to the book
        logic [15:0] qty;
        logic [31:0] id;        // assigned id (submit) or id to cancel
    } cmd_t;

    // one result record
    typedef struct packed {
        logic [31:0] trade_number;
        logic [31:0] buyer_id;
        logic [31:0] seller_id;
        logic [9:0]  fill_price;
        logic [15:0] fill_qty;
        logic [31:0] assigned_id;
        logic [2:0]  status;
        logic [15:0] rested_qty;
        logic [9:0]  best_bid;
        logic [9:0]  best_ask;
        logic [1:0]  sides_present;
        logic        last;
    } res_t;

endpackage
`default_nettype wire

[sv/lome_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lome_if: request and result channels of the matching engine
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lome_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        side;
    logic [9:0]  price;
    logic [15:0] quantity;
    logic [31:0] cancel_id;

    modport source (output valid, cmd, side, price, quantity, cancel_id, input ready);
    modport sink   (input valid, cmd, side, price, quantity, cancel_id, output ready);
endinterface

interface lome_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] trade_number;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [9:0]  fill_price;
    logic [15:0] fill_qty;
    logic [31:0] assigned_id;
    logic [2:0]  status;
    logic [15:0] rested_qty;
    logic [9:0]  best_bid;
    logic [9:0]  best_ask;
    logic [1:0]  sides_present;
    logic        last;

    modport source (output valid, trade_number, buyer_id, seller_id, fill_price, fill_qty,
                    assigned_id, status, rested_qty, best_bid, best_ask, sides_present,
                    last, input ready);
    modport sink   (input valid, trade_number, buyer_id, seller_id, fill_price, fill_qty,
                    assigned_id, status, rested_qty, best_bid, best_ask, sides_present,
                    last, output ready);
endinterface
`default_nettype wire

[sv/lome_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lome_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held while
// read enable is low.
// ----------------------------------------------------------------------------
module lome_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

[sv/lome_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lome_front: request intake
// Takes requests, clamps the price to the book, hands out order ids and
// pushes classified requests into the queue.
// ----------------------------------------------------------------------------
module lome_front #(
    parameter int PRICE_LEVELS = lome_pkg::LOME_PRICE_LEVELS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lome_in_if.sink            order,
    input  wire logic          init_done,
    input  wire logic          q_full,
    output logic               q_push,
    output lome_pkg::cmd_t     q_data
);

    localparam int PMAX = (PRICE_LEVELS > 1024) ? 1023 : PRICE_LEVELS - 1;

    logic [31:0] order_num_reg;
    logic [31:0] order_num_next;
    logic        accept;

    assign order.ready = init_done && !q_full;
    assign accept      = order.valid && order.ready;
    assign q_push      = accept;

    // classify the request
    always_comb
    begin
        q_data.cmd   = order.cmd;
        q_data.side  = order.side;
        q_data.price = (order.price > 10'(PMAX)) ? 10'(PMAX) : order.price;
        q_data.qty   = order.quantity;
        q_data.id    = (order.cmd == lome_pkg::CMD_CANCEL) ? order.cancel_id
                                                            : order_num_reg;
        order_num_next = order_num_reg;
        if (accept && order.cmd == lome_pkg::CMD_SUBMIT)
        begin
            order_num_next = order_num_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_num_reg <= 32'd1;
        end
        else
        begin
            order_num_reg <= order_num_next;
        end
    end

endmodule
`default_nettype wire

[sv/lome_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lome_queue: two-entry request queue
// Decouples the intake from the book sequencer.
// ----------------------------------------------------------------------------
module lome_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lome_pkg::cmd_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output lome_pkg::cmd_t      data
);

    lome_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign data  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

[sv/lome_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lome_back: order book sequencer
// Clears the book after reset, then carries out one queued request at a
// time against the slot and level memories and drives the result register.
// ----------------------------------------------------------------------------
module lome_back #(
    parameter int PRICE_LEVELS = lome_pkg::LOME_PRICE_LEVELS,
    parameter int ORDER_SLOTS  = lome_pkg::LOME_ORDER_SLOTS,
    parameter int MAX_FILLS    = lome_pkg::LOME_MAX_FILLS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire lome_pkg::cmd_t q_data,
    output logic                q_pop,
    output logic                init_done,
    lome_out_if.source          result
);

    localparam int SW    = $clog2(ORDER_SLOTS);
    localparam int LW    = $clog2(PRICE_LEVELS);
    localparam int IW    = $clog2(2 * PRICE_LEVELS);
    localparam int FW    = $clog2(MAX_FILLS + 1);
    localparam int CLR_N = (ORDER_SLOTS > 2 * PRICE_LEVELS) ? ORDER_SLOTS : 2 * PRICE_LEVELS;
    localparam int CW    = $clog2(CLR_N + 1);

    typedef struct packed {
        logic [31:0]   oid;
        logic [15:0]   qty;
        logic [LW-1:0] lvl;
        logic          ask;
        logic [SW-1:0] nxt;
        logic [SW-1:0] prv;
        logic          used;
    } slot_t;

    typedef struct packed {
        logic [SW-1:0] head;
        logic [SW-1:0] tail;
        logic          occ;
    } level_t;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_MATCH  = 4'd2;
    localparam logic [3:0] S_M_LVL  = 4'd3;
    localparam logic [3:0] S_M_SLOT = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_FREE   = 4'd6;
    localparam logic [3:0] S_LINK   = 4'd7;
    localparam logic [3:0] S_LINK_T = 4'd8;
    localparam logic [3:0] S_CSCAN  = 4'd9;
    localparam logic [3:0] S_C_LVL  = 4'd10;
    localparam logic [3:0] S_C_PV   = 4'd11;
    localparam logic [3:0] S_C_NX   = 4'd12;
    localparam logic [3:0] S_FINAL  = 4'd13;

    // level memory index: side * PRICE_LEVELS + level
    function automatic logic [IW-1:0] lidx(input logic ask, input logic [LW-1:0] lv);
        lidx = (ask ? IW'(PRICE_LEVELS) : '0) + IW'(lv);
    endfunction

    // memory ports
    logic          s_we, s_re, l_we, l_re;
    logic [SW-1:0] s_waddr, s_raddr;
    logic [IW-1:0] l_waddr, l_raddr;
    slot_t         s_wdata, s_rd;
    level_t        l_wdata, l_rd;

    lome_ram #(.WIDTH($bits(slot_t)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .re(s_re), .raddr(s_raddr), .rdata(s_rd)
    );

    lome_ram #(.WIDTH($bits(level_t)), .DEPTH(2 * PRICE_LEVELS)) u_level_ram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .re(l_re), .raddr(l_raddr), .rdata(l_rd)
    );

    // registers
    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       clr_reg, clr_next;
    logic                side_reg, side_next;
    logic [LW-1:0]       price_reg, price_next;
    logic [15:0]         rem_reg, rem_next;
    logic [31:0]         id_reg, id_next;
    logic [FW-1:0]       fills_reg, fills_next;
    logic [31:0]         trade_reg, trade_next;
    logic [LW-1:0]       bb_reg, bb_next, ba_reg, ba_next;
    logic                bid_p_reg, bid_p_next, ask_p_reg, ask_p_next;
    logic [SW-1:0]       scur_reg, scur_next;
    logic [LW-1:0]       lcur_reg, lcur_next;
    logic [SW-1:0]       s_reg, s_next;
    logic [SW-1:0]       pv_reg, pv_next, nx_reg, nx_next;
    logic [2:0]          status_reg, status_next;
    logic [15:0]         rested_reg, rested_next;
    logic                scan_side_reg, scan_side_next;
    logic                ret_final_reg, ret_final_next;
    logic                o_valid_reg, o_valid_next;
    lome_pkg::res_t      o_reg, o_next;

    // scan launch request from the unlink states
    logic          scan_go;
    logic          scan_side;
    logic [LW-1:0] scan_from;
    logic          scan_ret_final;

    logic          out_free;
    logic          crosses;
    logic [15:0]   fill;
    logic [15:0]   q_left;
    slot_t         new_slot;

    assign out_free  = !o_valid_reg || result.ready;
    assign init_done = (state_reg != S_CLR);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        rem_next       = rem_reg;
        id_next        = id_reg;
        fills_next     = fills_reg;
        trade_next     = trade_reg;
        bb_next        = bb_reg;
        ba_next        = ba_reg;
        bid_p_next     = bid_p_reg;
        ask_p_next     = ask_p_reg;
        scur_next      = scur_reg;
        lcur_next      = lcur_reg;
        s_next         = s_reg;
        pv_next        = pv_reg;
        nx_next        = nx_reg;
        status_next    = status_reg;
        rested_next    = rested_reg;
        scan_side_next = scan_side_reg;
        ret_final_next = ret_final_reg;
        o_valid_next   = o_valid_reg && !result.ready;
        o_next         = o_reg;
        q_pop          = 1'b0;
        s_we           = 1'b0;
        s_waddr        = '0;
        s_wdata        = '0;
        s_re           = 1'b0;
        s_raddr        = '0;
        l_we           = 1'b0;
        l_waddr        = '0;
        l_wdata        = '0;
        l_re           = 1'b0;
        l_raddr        = '0;
        scan_go        = 1'b0;
        scan_side      = 1'b0;
        scan_from      = '0;
        scan_ret_final = 1'b0;

        // the incoming order crosses the best opposite level
        if (side_reg == lome_pkg::SIDE_BID)
        begin
            crosses = ask_p_reg && (ba_reg <= price_reg);
        end
        else
        begin
            crosses = bid_p_reg && (bb_reg >= price_reg);
        end
        fill   = (rem_reg < s_rd.qty) ? rem_reg : s_rd.qty;
        q_left = s_rd.qty - fill;

        new_slot.oid  = id_reg;
        new_slot.qty  = rem_reg;
        new_slot.lvl  = price_reg;
        new_slot.ask  = side_reg;
        new_slot.nxt  = '0;
        new_slot.prv  = '0;
        new_slot.used = 1'b1;

        case (state_reg)
            // zero both memories, one entry a cycle
            S_CLR:
            begin
                if (clr_reg < CW'(ORDER_SLOTS))
                begin
                    s_we    = 1'b1;
                    s_waddr = clr_reg[SW-1:0];
                end
                if (clr_reg < CW'(2 * PRICE_LEVELS))
                begin
                    l_we    = 1'b1;
                    l_waddr = clr_reg[IW-1:0];
                end
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // take the next request off the queue
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    side_next   = q_data.side;
                    price_next  = LW'(q_data.price);
                    rem_next    = q_data.qty;
                    id_next     = q_data.id;
                    fills_next  = '0;
                    rested_next = '0;
                    if (q_data.cmd == lome_pkg::CMD_CANCEL)
                    begin
                        status_next = lome_pkg::ST_NOTFOUND;
                        scur_next   = '0;
                        s_re        = 1'b1;
                        s_raddr     = '0;
                        state_next  = S_CSCAN;
                    end
                    else
                    begin
                        state_next = S_MATCH;
                    end
                end
            end

            // decide whether to trade again
            S_MATCH:
            begin
                if (rem_reg != 16'd0 && fills_reg < FW'(MAX_FILLS) && crosses)
                begin
                    l_re       = 1'b1;
                    l_raddr    = lidx(~side_reg, side_reg ? bb_reg : ba_reg);
                    state_next = S_M_LVL;
                end
                else if (rem_reg == 16'd0)
                begin
                    status_next = lome_pkg::ST_NOLEFT;
                    state_next  = S_FINAL;
                end
                else if (fills_reg >= FW'(MAX_FILLS))
                begin
                    status_next = lome_pkg::ST_FILLDROP;
                    state_next  = S_FINAL;
                end
                else
                begin
                    scur_next  = '0;
                    s_re       = 1'b1;
                    s_raddr    = '0;
                    state_next = S_FREE;
                end
            end

            // best opposite level read: fetch its oldest order
            S_M_LVL:
            begin
                s_next     = l_rd.head;
                s_re       = 1'b1;
                s_raddr    = l_rd.head;
                state_next = S_M_SLOT;
            end

            // one fill against the head order
            S_M_SLOT:
            begin
                if (out_free)
                begin
                    o_valid_next           = 1'b1;
                    o_next                 = '0;
                    o_next.trade_number    = trade_reg;
                    o_next.buyer_id        = side_reg ? s_rd.oid : id_reg;
                    o_next.seller_id       = side_reg ? id_reg : s_rd.oid;
                    o_next.fill_price      = 10'(s_rd.lvl);
                    o_next.fill_qty        = fill;
                    o_next.assigned_id     = id_reg;
                    trade_next             = trade_reg + 32'd1;
                    fills_next             = fills_reg + FW'(1);
                    rem_next               = rem_reg - fill;
                    s_we                   = 1'b1;
                    s_waddr                = s_reg;
                    s_wdata                = s_rd;
                    s_wdata.qty            = q_left;
                    state_next             = S_MATCH;
                    if (q_left == 16'd0)
                    begin
                        s_wdata.used = 1'b0;
                        l_we         = 1'b1;
                        l_waddr      = lidx(s_rd.ask, s_rd.lvl);
                        l_wdata      = l_rd;
                        if (l_rd.tail == s_reg)
                        begin
                            l_wdata.occ = 1'b0;
                            scan_go     = 1'b1;
                            scan_side   = s_rd.ask;
                            scan_from   = s_rd.lvl;
                        end
                        else
                        begin
                            l_wdata.head = s_rd.nxt;
                        end
                    end
                end
            end

            // look for the next occupied level, one per cycle
            S_SCAN:
            begin
                if (l_rd.occ)
                begin
                    if (scan_side_reg)
                    begin
                        ba_next    = lcur_reg;
                        ask_p_next = 1'b1;
                    end
                    else
                    begin
                        bb_next    = lcur_reg;
                        bid_p_next = 1'b1;
                    end
                    state_next = ret_final_reg ? S_FINAL : S_MATCH;
                end
                else if (scan_side_reg ? (lcur_reg == LW'(PRICE_LEVELS - 1))
                                       : (lcur_reg == '0))
                begin
                    if (scan_side_reg)
                    begin
                        ba_next    = '0;
                        ask_p_next = 1'b0;
                    end
                    else
                    begin
                        bb_next    = '0;
                        bid_p_next = 1'b0;
                    end
                    state_next = ret_final_reg ? S_FINAL : S_MATCH;
                end
                else
                begin
                    lcur_next = scan_side_reg ? lcur_reg + LW'(1) : lcur_reg - LW'(1);
                    l_re      = 1'b1;
                    l_raddr   = lidx(scan_side_reg, lcur_next);
                end
            end

            // lowest free slot for the remainder
            S_FREE:
            begin
                if (!s_rd.used)
                begin
                    s_next     = scur_reg;
                    l_re       = 1'b1;
                    l_raddr    = lidx(side_reg, price_reg);
                    state_next = S_LINK;
                end
                else if (scur_reg == SW'(ORDER_SLOTS - 1))
                begin
                    status_next = lome_pkg::ST_FULL;
                    state_next  = S_FINAL;
                end
                else
                begin
                    scur_next = scur_reg + SW'(1);
                    s_re      = 1'b1;
                    s_raddr   = scur_next;
                end
            end

            // append the new order at the tail of its level
            S_LINK:
            begin
                s_we         = 1'b1;
                s_waddr      = s_reg;
                s_wdata      = new_slot;
                l_we         = 1'b1;
                l_waddr      = lidx(side_reg, price_reg);
                l_wdata.head = l_rd.occ ? l_rd.head : s_reg;
                l_wdata.tail = s_reg;
                l_wdata.occ  = 1'b1;
                status_next  = lome_pkg::ST_RESTED;
                rested_next  = rem_reg;
                if (side_reg == lome_pkg::SIDE_BID)
                begin
                    if (!bid_p_reg || price_reg > bb_reg)
                    begin
                        bb_next    = price_reg;
                        bid_p_next = 1'b1;
                    end
                end
                else if (!ask_p_reg || price_reg < ba_reg)
                begin
                    ba_next    = price_reg;
                    ask_p_next = 1'b1;
                end
                if (l_rd.occ)
                begin
                    s_wdata.prv = l_rd.tail;
                    pv_next     = l_rd.tail;
                    s_re        = 1'b1;
                    s_raddr     = l_rd.tail;
                    state_next  = S_LINK_T;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end

            // old tail points at the new order
            S_LINK_T:
            begin
                s_we        = 1'b1;
                s_waddr     = pv_reg;
                s_wdata     = s_rd;
                s_wdata.nxt = s_reg;
                state_next  = S_FINAL;
            end

            // search the slots for the id to cancel
            S_CSCAN:
            begin
                if (s_rd.used && s_rd.oid == id_reg)
                begin
                    s_next      = scur_reg;
                    pv_next     = s_rd.prv;
                    nx_next     = s_rd.nxt;
                    status_next = lome_pkg::ST_CANCELLED;
                    l_re        = 1'b1;
                    l_raddr     = lidx(s_rd.ask, s_rd.lvl);
                    state_next  = S_C_LVL;
                end
                else if (scur_reg == SW'(ORDER_SLOTS - 1))
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    scur_next = scur_reg + SW'(1);
                    s_re      = 1'b1;
                    s_raddr   = scur_next;
                end
            end

            // unlink the cancelled order from its level
            S_C_LVL:
            begin
                s_we         = 1'b1;
                s_waddr      = s_reg;
                s_wdata      = s_rd;
                s_wdata.used = 1'b0;
                l_waddr      = lidx(s_rd.ask, s_rd.lvl);
                l_wdata      = l_rd;
                state_next   = S_FINAL;
                if (l_rd.head == s_reg && l_rd.tail == s_reg)
                begin
                    l_we        = 1'b1;
                    l_wdata.occ = 1'b0;
                    if (s_rd.lvl == (s_rd.ask ? ba_reg : bb_reg))
                    begin
                        scan_go        = 1'b1;
                        scan_side      = s_rd.ask;
                        scan_from      = s_rd.lvl;
                        scan_ret_final = 1'b1;
                    end
                end
                else if (l_rd.head == s_reg)
                begin
                    l_we         = 1'b1;
                    l_wdata.head = nx_reg;
                end
                else if (l_rd.tail == s_reg)
                begin
                    l_we         = 1'b1;
                    l_wdata.tail = pv_reg;
                end
                else
                begin
                    s_re       = 1'b1;
                    s_raddr    = pv_reg;
                    state_next = S_C_PV;
                end
            end

            // predecessor skips the cancelled order
            S_C_PV:
            begin
                s_we        = 1'b1;
                s_waddr     = pv_reg;
                s_wdata     = s_rd;
                s_wdata.nxt = nx_reg;
                s_re        = 1'b1;
                s_raddr     = nx_reg;
                state_next  = S_C_NX;
            end

            // successor points back past it
            S_C_NX:
            begin
                s_we        = 1'b1;
                s_waddr     = nx_reg;
                s_wdata     = s_rd;
                s_wdata.prv = pv_reg;
                state_next  = S_FINAL;
            end

            // final status result
            S_FINAL:
            begin
                if (out_free)
                begin
                    o_valid_next         = 1'b1;
                    o_next               = '0;
                    o_next.assigned_id   = id_reg;
                    o_next.status        = status_reg;
                    o_next.rested_qty    = rested_reg;
                    o_next.best_bid      = 10'(bb_reg);
                    o_next.best_ask      = 10'(ba_reg);
                    o_next.sides_present = {ask_p_reg, bid_p_reg};
                    o_next.last          = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // launch a best-level rescan after a level empties
        if (scan_go)
        begin
            scan_side_next = scan_side;
            ret_final_next = scan_ret_final;
            if (scan_side ? (scan_from == LW'(PRICE_LEVELS - 1)) : (scan_from == '0))
            begin
                if (scan_side)
                begin
                    ba_next    = '0;
                    ask_p_next = 1'b0;
                end
                else
                begin
                    bb_next    = '0;
                    bid_p_next = 1'b0;
                end
            end
            else
            begin
                lcur_next  = scan_side ? scan_from + LW'(1) : scan_from - LW'(1);
                l_re       = 1'b1;
                l_raddr    = lidx(scan_side, lcur_next);
                state_next = S_SCAN;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            trade_reg   <= 32'd1;
            bb_reg      <= '0;
            ba_reg      <= '0;
            bid_p_reg   <= 1'b0;
            ask_p_reg   <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            trade_reg   <= trade_next;
            bb_reg      <= bb_next;
            ba_reg      <= ba_next;
            bid_p_reg   <= bid_p_next;
            ask_p_reg   <= ask_p_next;
            o_valid_reg <= o_valid_next;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        side_reg      <= side_next;
        price_reg     <= price_next;
        rem_reg       <= rem_next;
        id_reg        <= id_next;
        fills_reg     <= fills_next;
        scur_reg      <= scur_next;
        lcur_reg      <= lcur_next;
        s_reg         <= s_next;
        pv_reg        <= pv_next;
        nx_reg        <= nx_next;
        status_reg    <= status_next;
        rested_reg    <= rested_next;
        scan_side_reg <= scan_side_next;
        ret_final_reg <= ret_final_next;
        o_reg         <= o_next;
    end

    assign result.valid         = o_valid_reg;
    assign result.trade_number  = o_reg.trade_number;
    assign result.buyer_id      = o_reg.buyer_id;
    assign result.seller_id     = o_reg.seller_id;
    assign result.fill_price    = o_reg.fill_price;
    assign result.fill_qty      = o_reg.fill_qty;
    assign result.assigned_id   = o_reg.assigned_id;
    assign result.status        = o_reg.status;
    assign result.rested_qty    = o_reg.rested_qty;
    assign result.best_bid      = o_reg.best_bid;
    assign result.best_ask      = o_reg.best_ask;
    assign result.sides_present = o_reg.sides_present;
    assign result.last          = o_reg.last;

endmodule
`default_nettype wire

[sv/limit_order_matching_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_matching_engine: price-time priority limit order book
// Intake and id assignment in front, a two-entry queue, and a sequencer
// that matches, rests and cancels orders in slot and level memories.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      carries
//  order     in    valid/ready    cmd, side, price, quantity, cancel_id
//  result    out   valid/ready    one trade per fill, then a final status
//
//  After reset a clearing pass zeroes both memories; order.ready stays low
//  until it ends.
//  A submit makes one fill at a time against the best opposite level, walks
//  level by level to a new best when a level empties, and, when a remainder
//  rests, searches the slots for the lowest free one and links it; a cancel
//  searches the slots for its id and unlinks it. These steps are set by the
//  single read port of each memory.
//  A stalled result holds the sequencer; the queue takes up to two more
//  requests, then order.ready drops.
// ----------------------------------------------------------------------------
module limit_order_matching_engine #(
    parameter int PRICE_LEVELS = lome_pkg::LOME_PRICE_LEVELS,
    parameter int ORDER_SLOTS  = lome_pkg::LOME_ORDER_SLOTS,
    parameter int MAX_FILLS    = lome_pkg::LOME_MAX_FILLS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lome_in_if.sink     order,
    lome_out_if.source  result
);

    logic           push, full, pop, q_valid, init_done;
    lome_pkg::cmd_t push_data, q_data;

    lome_front #(.PRICE_LEVELS(PRICE_LEVELS)) u_front (
        .clk(clk), .rst_n(rst_n), .order(order), .init_done(init_done),
        .q_full(full), .q_push(push), .q_data(push_data)
    );

    lome_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(full),
        .pop(pop), .valid(q_valid), .data(q_data)
    );

    lome_back #(
        .PRICE_LEVELS(PRICE_LEVELS),
        .ORDER_SLOTS(ORDER_SLOTS),
        .MAX_FILLS(MAX_FILLS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(pop),
        .init_done(init_done), .result(result)
    );

endmodule
`default_nettype wire

[tb/sv/lome_book_checker.sv]
// ----------------------------------------------------------------------------
// lome_book_checker: result checker for the limit order matching engine
// Keeps its own copy of the order book, predicts trades and final status for
// every accepted request and compares each accepted result against the
// oldest prediction.
// ----------------------------------------------------------------------------
module lome_book_checker (
    input  logic clk,
    input  logic rst_n,
    lome_in_if   order,
    lome_out_if  result,
    output int   fail_count,
    output int   pending
);

    localparam int NLV   = lome_pkg::LOME_PRICE_LEVELS;
    localparam int NSL   = lome_pkg::LOME_ORDER_SLOTS;
    localparam int PDEPTH = 1024;

    // book copy
    logic [31:0] slot_oid [NSL];
    logic [15:0] slot_qty [NSL];
    logic [9:0]  slot_lvl [NSL];
    logic        slot_ask [NSL];
    int          slot_nx  [NSL];
    int          slot_pv  [NSL];
    bit          slot_busy[NSL];
    int          lvl_head [2*NLV];
    int          lvl_tail [2*NLV];
    bit          lvl_busy [2*NLV];
    logic [31:0] order_no;
    logic [31:0] trade_no;

    // expected results, oldest first
    lome_pkg::res_t pred_buf [PDEPTH];
    int             wr_cnt;
    int             rd_cnt;

    assign pending = wr_cnt - rd_cnt;

    function automatic void put_expected(input lome_pkg::res_t r);
        pred_buf[wr_cnt % PDEPTH] = r;
        wr_cnt++;
    endfunction

    // best level of one side: highest bid, lowest ask
    function automatic bit best_level(input bit ask, output int lv);
        lv = 0;
        if (ask)
        begin
            for (int i = 0; i < NLV; i++)
                if (lvl_busy[NLV+i])
                begin
                    lv = i;
                    return 1'b1;
                end
        end
        else
        begin
            for (int i = NLV - 1; i >= 0; i--)
                if (lvl_busy[i])
                begin
                    lv = i;
                    return 1'b1;
                end
        end
        return 1'b0;
    endfunction

    function automatic void unlink(input int s);
        int idx;
        idx = (slot_ask[s] ? NLV : 0) + slot_lvl[s];
        if (lvl_head[idx] == s && lvl_tail[idx] == s)
            lvl_busy[idx] = 1'b0;
        else if (lvl_head[idx] == s)
            lvl_head[idx] = slot_nx[s];
        else if (lvl_tail[idx] == s)
            lvl_tail[idx] = slot_pv[s];
        else
        begin
            slot_nx[slot_pv[s]] = slot_nx[s];
            slot_pv[slot_nx[s]] = slot_pv[s];
        end
        slot_busy[s] = 1'b0;
    endfunction

    function automatic void link(input int s);
        int idx;
        idx = (slot_ask[s] ? NLV : 0) + slot_lvl[s];
        if (!lvl_busy[idx])
        begin
            lvl_head[idx] = s;
            lvl_tail[idx] = s;
            lvl_busy[idx] = 1'b1;
        end
        else
        begin
            slot_nx[lvl_tail[idx]] = s;
            slot_pv[s] = lvl_tail[idx];
            lvl_tail[idx] = s;
        end
        slot_busy[s] = 1'b1;
    endfunction

    // predict the trades and the final status of one request
    function automatic void predict_request(input logic cmd, input logic side,
                                            input logic [9:0] price,
                                            input logic [15:0] qty,
                                            input logic [31:0] cid);
        lome_pkg::res_t r;
        logic [15:0] left, f;
        logic [31:0] aid;
        logic [2:0] st;
        logic [15:0] rested;
        int fills, lv, s, bb, ba;
        bit hb, ha;
        left = qty;
        rested = '0;
        fills = 0;
        if (cmd == lome_pkg::CMD_SUBMIT)
        begin
            aid = order_no;
            order_no = order_no + 1;
            while (left > 0 && fills < lome_pkg::LOME_MAX_FILLS)
            begin
                if (!best_level(side == lome_pkg::SIDE_BID, lv)) break;
                if (side == lome_pkg::SIDE_BID && lv > price) break;
                if (side == lome_pkg::SIDE_ASK && lv < price) break;
                s = lvl_head[(side == lome_pkg::SIDE_BID ? NLV : 0) + lv];
                f = (left < slot_qty[s]) ? left : slot_qty[s];
                r = '0;
                r.trade_number = trade_no;
                r.buyer_id     = (side == lome_pkg::SIDE_BID) ? aid : slot_oid[s];
                r.seller_id    = (side == lome_pkg::SIDE_ASK) ? aid : slot_oid[s];
                r.fill_price   = lv[9:0];
                r.fill_qty     = f;
                r.assigned_id  = aid;
                put_expected(r);
                fills++;
                trade_no = trade_no + 1;
                slot_qty[s] = slot_qty[s] - f;
                left = left - f;
                if (slot_qty[s] == 0) unlink(s);
            end
            if (left == 0)
                st = lome_pkg::ST_NOLEFT;
            else if (fills >= lome_pkg::LOME_MAX_FILLS)
                st = lome_pkg::ST_FILLDROP;
            else
            begin
                for (s = 0; s < NSL; s++)
                    if (!slot_busy[s]) break;
                if (s >= NSL)
                    st = lome_pkg::ST_FULL;
                else
                begin
                    slot_oid[s] = aid;
                    slot_qty[s] = left;
                    slot_lvl[s] = price;
                    slot_ask[s] = side;
                    slot_nx[s]  = 0;
                    slot_pv[s]  = 0;
                    link(s);
                    st = lome_pkg::ST_RESTED;
                    rested = left;
                end
            end
        end
        else
        begin
            aid = cid;
            st = lome_pkg::ST_NOTFOUND;
            for (s = 0; s < NSL; s++)
                if (slot_busy[s] && slot_oid[s] == cid)
                begin
                    unlink(s);
                    st = lome_pkg::ST_CANCELLED;
                    break;
                end
        end
        hb = best_level(1'b0, bb);
        ha = best_level(1'b1, ba);
        r = '0;
        r.assigned_id   = aid;
        r.status        = st;
        r.rested_qty    = rested;
        r.best_bid      = bb[9:0];
        r.best_ask      = ba[9:0];
        r.sides_present = {ha, hb};
        r.last          = 1'b1;
        put_expected(r);
    endfunction

    lome_pkg::res_t seen, want;
    always_comb
    begin
        seen.trade_number  = result.trade_number;
        seen.buyer_id      = result.buyer_id;
        seen.seller_id     = result.seller_id;
        seen.fill_price    = result.fill_price;
        seen.fill_qty      = result.fill_qty;
        seen.assigned_id   = result.assigned_id;
        seen.status        = result.status;
        seen.rested_qty    = result.rested_qty;
        seen.best_bid      = result.best_bid;
        seen.best_ask      = result.best_ask;
        seen.sides_present = result.sides_present;
        seen.last          = result.last;
    end

    // book reset, prediction on request, comparison on result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSL; i++) slot_busy[i] = 1'b0;
            for (int i = 0; i < 2*NLV; i++) lvl_busy[i] = 1'b0;
            order_no = 32'd1;
            trade_no = 32'd1;
            fail_count = 0;
            wr_cnt = 0;
            rd_cnt = 0;
        end
        else
        begin
            if (order.valid && order.ready)
                predict_request(order.cmd, order.side, order.price, order.quantity,
                                order.cancel_id);
            if (result.valid && result.ready)
            begin
                if (wr_cnt == rd_cnt)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: %p", seen);
                end
                else
                begin
                    want = pred_buf[rd_cnt % PDEPTH];
                    rd_cnt++;
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch trade %0d/%0d buyer %0d/%0d seller %0d/%0d",
                                      " px %0d/%0d fq %0d/%0d id %0d/%0d st %0d/%0d",
                                      " rq %0d/%0d bb %0d/%0d ba %0d/%0d sp %0d/%0d",
                                      " last %0d/%0d (exp/act)"},
                                     want.trade_number, seen.trade_number,
                                     want.buyer_id, seen.buyer_id,
                                     want.seller_id, seen.seller_id,
                                     want.fill_price, seen.fill_price,
                                     want.fill_qty, seen.fill_qty,
                                     want.assigned_id, seen.assigned_id,
                                     want.status, seen.status,
                                     want.rested_qty, seen.rested_qty,
                                     want.best_bid, seen.best_bid,
                                     want.best_ask, seen.best_ask,
                                     want.sides_present, seen.sides_present,
                                     want.last, seen.last);
                    end
                end
            end
        end
    end

endmodule

[tb/sv/tb_limit_order_matching_engine.sv]
// ----------------------------------------------------------------------------
// tb_limit_order_matching_engine: stimulus and verdict for the order book
// Directed corner requests, then random submits and cancels with random
// gaps and result stalls, and one long result stall.
// ----------------------------------------------------------------------------
module tb_limit_order_matching_engine;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   next_id;
    int   results_taken;

    lome_in_if  order();
    lome_out_if result();

    limit_order_matching_engine uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .order  (order),
        .result (result)
    );

    lome_book_checker book_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .order      (order),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    // one request, after a random gap unless no_gap
    task automatic send_request(input logic cmd, input logic side, input logic [9:0] price,
                                input logic [15:0] qty, input logic [31:0] cid,
                                input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            order.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        order.valid     <= 1'b1;
        order.cmd       <= cmd;
        order.side      <= side;
        order.price     <= price;
        order.quantity  <= qty;
        order.cancel_id <= cid;
        do @(posedge clk); while (!order.ready);
        if (cmd == lome_pkg::CMD_SUBMIT) next_id++;
    endtask

    task automatic submit(input logic side, input logic [9:0] price, input logic [15:0] qty,
                          input bit no_gap = 1'b0);
        send_request(lome_pkg::CMD_SUBMIT, side, price, qty, $urandom, no_gap);
    endtask

    task automatic cancel(input logic [31:0] cid);
        send_request(lome_pkg::CMD_CANCEL, 1'($urandom_range(0, 1)), 10'($urandom),
                     16'($urandom), cid);
    endtask

    // result side: random stalls, one long hold-off
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        results_taken = 0;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (!held && results_taken >= 20)
            begin
                held = 1'b1;
                gap = 400;
            end
            if (gap > 0)
            begin
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
            results_taken++;
        end
    end

    // stimulus
    initial
    begin
        int n;
        order.valid = 1'b0;
        order.cmd = lome_pkg::CMD_SUBMIT;
        order.side = lome_pkg::SIDE_BID;
        order.price = '0;
        order.quantity = '0;
        order.cancel_id = '0;
        next_id = 1;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        submit(lome_pkg::SIDE_BID, 10'd0, 16'd0);            // zero quantity
        submit(lome_pkg::SIDE_ASK, 10'd1023, 16'hFFFF);      // rests at top
        submit(lome_pkg::SIDE_BID, 10'd1023, 16'd10);        // crosses, fills at once
        cancel(32'd3);                                       // id already filled
        cancel(32'd0);
        cancel(32'hFFFF_FFFF);
        cancel(32'd2);                                       // resting remainder
        submit(lome_pkg::SIDE_BID, 10'd0, 16'hFFFF);
        submit(lome_pkg::SIDE_ASK, 10'd0, 16'hFFFF);         // full fill at bottom
        // fill limit: more small asks than one order may hit
        for (int i = 0; i < 64; i++) submit(lome_pkg::SIDE_ASK, 10'd500, 16'd1);
        submit(lome_pkg::SIDE_BID, 10'd600, 16'd100);
        submit(lome_pkg::SIDE_BID, 10'd499, 16'd7);
        cancel(next_id - 1);

        // random mix around a busy mid price
        for (int i = 0; i < 55; i++)
        begin
            n = $urandom_range(0, 99);
            if (n < 60)
                submit(1'($urandom_range(0, 1)), 10'($urandom_range(480, 520)),
                       16'($urandom_range(1, 300)));
            else if (n < 70)
                submit(1'($urandom_range(0, 1)), 10'($urandom), 16'($urandom));
            else if (n < 90)
                cancel($urandom_range(1, next_id));
            else
                cancel($urandom);
        end

        order.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
